@@ hw/rtl/u8id_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8id_pkg
// Shared types and constants for the UTF-8 identifier checker.
// ----------------------------------------------------------------------------
package u8id_pkg;

    localparam int CODE_W        = 21;
    localparam int COUNT_W       = 9;
    localparam int LEN_W         = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [LEN_W-1:0]   MAX_LENGTH_RESET = 8'd64;
    localparam logic [COUNT_W-1:0] COUNT_SAT        = 9'd256;
    localparam logic [CODE_W-1:0]  CODE_MAX         = 21'h00FFFF;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_EMPTY    = 2'd1;
    localparam logic [1:0] VERDICT_TOO_LONG = 2'd2;
    localparam logic [1:0] VERDICT_BAD_CHAR = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_identifier;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        verdict;
        logic [CODE_W-1:0] bad_code_point;
    } out_item_t;

    // Classified byte handed from front to back
    typedef struct packed {
        logic       empty_identifier;
        logic       last_byte;
        logic [7:0] data_byte;
        logic       stray;         // continuation or 0xF8+ in lead position
        logic [1:0] lead_pending;  // continuation bytes a lead byte asks for
        logic [6:0] lead_bits;     // payload bits of the lead byte
    } cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/u8id_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8id_front
// Accepts input items and classifies each byte as a lead byte form.
// ----------------------------------------------------------------------------
module u8id_front
    import u8id_pkg::*;
(
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    logic [7:0] b;

    assign b         = in_item.data_byte;
    assign cmd_valid = in_valid;
    assign in_ready  = cmd_ready;

    always_comb
    begin
        cmd.empty_identifier = in_item.empty_identifier;
        cmd.last_byte        = in_item.last_byte;
        cmd.data_byte        = b;
        cmd.stray            = 1'b0;
        cmd.lead_pending     = 2'd0;
        cmd.lead_bits        = 7'd0;
        if (b[7] == 1'b0)
        begin
            cmd.lead_bits = b[6:0];
        end
        else if ((b & 8'hE0) == 8'hC0)
        begin
            cmd.lead_pending = 2'd1;
            cmd.lead_bits    = {2'b00, b[4:0]};
        end
        else if ((b & 8'hF0) == 8'hE0)
        begin
            cmd.lead_pending = 2'd2;
            cmd.lead_bits    = {3'b000, b[3:0]};
        end
        else if ((b & 8'hF8) == 8'hF0)
        begin
            cmd.lead_pending = 2'd3;
            cmd.lead_bits    = {4'b0000, b[2:0]};
        end
        else
        begin
            cmd.stray = 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/u8id_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8id_queue
// Small FIFO between the classifier and the decoder.
// ----------------------------------------------------------------------------
module u8id_queue
    import u8id_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_data,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign empty      = (count_reg == '0);
    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/u8id_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u8id_back
// Assembles code points, tracks length and the first bad code point, and
// registers one verdict per identifier.
// ----------------------------------------------------------------------------
module u8id_back
    import u8id_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [LEN_W-1:0] max_length,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire cmd_t             cmd,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_item
);

    logic [1:0]         pending_reg, pending_next;
    logic [CODE_W-1:0]  partial_reg, partial_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               seen_reg, seen_next;
    logic [CODE_W-1:0]  first_reg, first_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;

    logic               take;
    logic [1:0]         pending_upd;
    logic [CODE_W-1:0]  partial_upd;
    logic [COUNT_W-1:0] count_upd;
    logic               code_en, code_bad;
    logic [CODE_W-1:0]  code_val;
    logic               seen1, seen2;
    logic [CODE_W-1:0]  first1, first2, trunc_code;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        count_upd   = (count_reg == COUNT_SAT) ? count_reg : count_reg + COUNT_W'(1);
        pending_upd = pending_reg;
        partial_upd = partial_reg;
        code_en     = 1'b0;
        code_val    = '0;
        if (pending_reg != 2'd0)
        begin
            // continuation position: take low six bits, no check
            partial_upd = {partial_reg[CODE_W-7:0], cmd.data_byte[5:0]};
            pending_upd = pending_reg - 2'd1;
            code_en     = (pending_upd == 2'd0);
            code_val    = partial_upd;
        end
        else if (cmd.stray)
        begin
            code_en = 1'b1;
        end
        else if (cmd.lead_pending == 2'd0)
        begin
            code_en  = 1'b1;
            code_val = {{(CODE_W-7){1'b0}}, cmd.lead_bits};
        end
        else
        begin
            partial_upd = {{(CODE_W-7){1'b0}}, cmd.lead_bits};
            pending_upd = cmd.lead_pending;
        end

        code_bad = (code_val == '0) || (code_val > CODE_MAX);
        seen1    = seen_reg || (code_en && code_bad);
        first1   = (code_en && code_bad && !seen_reg) ? code_val : first_reg;

        // truncated sequence: pad missing bits with zero
        case (pending_upd)
            2'd1:    trunc_code = {partial_upd[CODE_W-7:0], 6'd0};
            2'd2:    trunc_code = {partial_upd[CODE_W-13:0], 12'd0};
            2'd3:    trunc_code = {partial_upd[CODE_W-19:0], 18'd0};
            default: trunc_code = '0;
        endcase

        seen2  = seen1;
        first2 = first1;
        if (pending_upd != 2'd0 && !seen1)
        begin
            seen2  = 1'b1;
            first2 = trunc_code;
        end
    end

    always_comb
    begin
        pending_next   = pending_reg;
        partial_next   = partial_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        if (take)
        begin
            if (cmd.empty_identifier || cmd.last_byte)
            begin
                pending_next   = 2'd0;
                partial_next   = '0;
                count_next     = '0;
                seen_next      = 1'b0;
                first_next     = '0;
                out_valid_next = 1'b1;
                out_item_next.bad_code_point = '0;
                if (cmd.empty_identifier)
                begin
                    out_item_next.verdict = VERDICT_EMPTY;
                end
                else if (count_upd > {1'b0, max_length})
                begin
                    out_item_next.verdict = VERDICT_TOO_LONG;
                end
                else if (seen2)
                begin
                    out_item_next.verdict        = VERDICT_BAD_CHAR;
                    out_item_next.bad_code_point = first2;
                end
                else
                begin
                    out_item_next.verdict = VERDICT_OK;
                end
            end
            else
            begin
                pending_next = pending_upd;
                partial_next = partial_upd;
                count_next   = count_upd;
                seen_next    = seen1;
                first_next   = first1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            partial_reg   <= '0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            partial_reg   <= partial_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/utf8_identifier_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_identifier_checker
// Checks an identifier, sent one byte per item, for UTF-8 code points in
// 1..0xFFFF and for a length limit, and gives one verdict per identifier.
//
// Input channel: in_valid/in_ready with in_item (byte, last mark, empty mark).
// Output channel: out_valid/out_ready with out_item (verdict, bad code point).
// Only a marked last byte or an empty item yields a result item.
// cfg_we/cfg_data write max_length; reset value 64.
// Throughput: one item per cycle; the decoder takes one queued byte a cycle unless a held result stalls it.
// A result item is registered once the decoder takes its last byte from the queue.
// A queue of QUEUE_DEPTH items sits between classifier and decoder; when the
// receiver stalls the result register holds, the queue fills and in_ready
// drops once it is full.
// Reset clears the queue, the decoder state and the result valid flag and
// sets max_length to 64.
// ----------------------------------------------------------------------------
module utf8_identifier_checker
    import u8id_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_item,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_data
);

    logic [LEN_W-1:0] max_length_reg, max_length_next;
    logic             f_valid, f_ready;
    cmd_t             f_cmd;
    logic             q_valid, q_ready;
    cmd_t             q_cmd;
    logic             q_full, q_empty;

    assign max_length_next = cfg_we ? cfg_data : max_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else
        begin
            max_length_reg <= max_length_next;
        end
    end

    u8id_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    u8id_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd),
        .full       (q_full),
        .empty      (q_empty)
    );

    u8id_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_length (max_length_reg),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .cmd        (q_cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !q_full)
        else $error("item accepted into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> (q_valid == !q_empty))
        else $error("decoder valid disagrees with queue state");

    a_code_only_on_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.verdict != VERDICT_BAD_CHAR)
            |-> (out_item.bad_code_point == '0))
        else $error("bad code point set on a verdict other than bad character");

    a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_valid && q_ready))
        else $error("result item without a decoded item");
`endif

endmodule
`default_nettype wire

@@ dv/u8id_verdict_checker.sv @@
// ----------------------------------------------------------------------------
// u8id_verdict_checker
// Watches both channels of the UTF-8 identifier checker. It decodes every
// accepted byte with its own copy of the decoder state and length limit,
// queues the verdict each identifier should get, and compares each result
// item, field by field, with the oldest queued verdict.
// ----------------------------------------------------------------------------
module u8id_verdict_checker
    import u8id_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire in_item_t         in_item,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire out_item_t        out_item,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    open_count,
    output int                    results_checked,
    output int                    verdict_hits [4]
);

    logic [LEN_W-1:0]   max_len;
    logic [1:0]         cont_left;
    logic [CODE_W-1:0]  code_acc;
    logic [COUNT_W-1:0] byte_total;
    logic               bad_seen;
    logic [CODE_W-1:0]  first_bad;
    out_item_t          verdict_q [$];
    out_item_t          head;

    task automatic clear_ident();
        cont_left  = '0;
        code_acc   = '0;
        byte_total = '0;
        bad_seen   = 1'b0;
        first_bad  = '0;
    endtask

    // Keep only the first code point that falls outside 1..0xFFFF or is forced bad
    task automatic record_code(input logic [CODE_W-1:0] code, input logic force_bad);
        if ((force_bad || code == '0 || code > CODE_MAX) && !bad_seen)
        begin
            bad_seen  = 1'b1;
            first_bad = code;
        end
    endtask

    task automatic decode_byte(input in_item_t it);
        out_item_t  res;
        logic [7:0] b;
        b   = it.data_byte;
        res = '0;
        if (it.empty_identifier)
        begin
            // drop whatever identifier was in progress
            clear_ident();
            res.verdict = VERDICT_EMPTY;
            verdict_q.push_back(res);
        end
        else
        begin
            if (byte_total < COUNT_SAT)
                byte_total = byte_total + 1'b1;
            if (cont_left != 2'd0)
            begin
                // high bits of a continuation byte are not checked
                code_acc  = {code_acc[CODE_W-7:0], b[5:0]};
                cont_left = cont_left - 1'b1;
                if (cont_left == 2'd0)
                    record_code(code_acc, 1'b0);
            end
            else if (!b[7])
                record_code(CODE_W'(b), 1'b0);
            else if (b[7:5] == 3'b110)
            begin
                code_acc  = CODE_W'(b[4:0]);
                cont_left = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                code_acc  = CODE_W'(b[3:0]);
                cont_left = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                code_acc  = CODE_W'(b[2:0]);
                cont_left = 2'd3;
            end
            else
                record_code('0, 1'b0);

            if (it.last_byte)
            begin
                // unfinished sequence: pad with zero bits, always offending
                if (cont_left != 2'd0)
                    record_code(code_acc << (6 * cont_left), 1'b1);
                if (byte_total > {1'b0, max_len})
                    res.verdict = VERDICT_TOO_LONG;
                else if (bad_seen)
                begin
                    res.verdict        = VERDICT_BAD_CHAR;
                    res.bad_code_point = first_bad;
                end
                else
                    res.verdict = VERDICT_OK;
                verdict_q.push_back(res);
                clear_ident();
            end
        end
    endtask

    task automatic report_miss(input string what, input out_item_t want);
        if (fail_count < 10)
            $display("%0t: %s: expected verdict %0d code 0x%06h, got verdict %0d code 0x%06h",
                     $time, what, want.verdict, want.bad_code_point,
                     out_item.verdict, out_item.bad_code_point);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len = MAX_LENGTH_RESET;
            clear_ident();
            verdict_q.delete();
            fail_count      = 0;
            open_count      = 0;
            results_checked = 0;
            for (int i = 0; i < 4; i++)
                verdict_hits[i] = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                    report_miss("unexpected result", '0);
                else
                begin
                    head = verdict_q.pop_front();
                    if (head.verdict != out_item.verdict
                        || head.bad_code_point != out_item.bad_code_point)
                        report_miss("mismatch", head);
                    results_checked++;
                    verdict_hits[out_item.verdict]++;
                end
            end
            if (in_valid && in_ready)
                decode_byte(in_item);
            // a write takes effect after any byte taken at the same edge
            if (cfg_we)
                max_len = cfg_data;
            open_count = verdict_q.size();
        end
    end

endmodule

@@ dv/utf8_identifier_checker_tb.sv @@
// ----------------------------------------------------------------------------
// utf8_identifier_checker_tb
// Drives byte streams into the UTF-8 identifier checker: a directed set of
// edge cases, then random identifiers (mostly well-formed, some noisy,
// truncated or aborted) under several length limits and idle/stall mixes.
// Checking is done by u8id_verdict_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module utf8_identifier_checker_tb;
    import u8id_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_item_t         in_item;
    logic             out_valid;
    logic             out_ready;
    out_item_t        out_item;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_data;

    int fail_count;
    int open_count;
    int results_checked;
    int verdict_hits [4];

    int         sender_idle_pct    = 0;
    int         receiver_stall_pct = 0;
    int         items_sent         = 0;
    logic [7:0] ident_q [$];

    utf8_identifier_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    u8id_verdict_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_item        (out_item),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .open_count      (open_count),
        .results_checked (results_checked),
        .verdict_hits    (verdict_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Call at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input in_item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.data_byte        = b;
        it.last_byte        = last;
        it.empty_identifier = 1'b0;
        send_item(it);
    endtask

    task automatic send_empty(input logic [7:0] b, input logic last);
        in_item_t it;
        it.data_byte        = b;
        it.last_byte        = last;
        it.empty_identifier = 1'b1;
        send_item(it);
    endtask

    task automatic send_ident();
        for (int i = 0; i < ident_q.size(); i++)
            send_byte(ident_q[i], i == ident_q.size() - 1);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic push_char(input bit noisy);
        int kind;
        kind = noisy ? $urandom_range(0, 99) : $urandom_range(0, 84);
        if (kind < 40)
            ident_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        else if (kind < 45)
            ident_q.push_back(8'($urandom_range(0, 127)));
        else if (kind < 60)
        begin
            ident_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            ident_q.push_back(cont_byte());
        end
        else if (kind < 75)
        begin
            ident_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            ident_q.push_back(cont_byte());
            ident_q.push_back(cont_byte());
        end
        else if (kind < 85)
        begin
            ident_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            repeat (3) ident_q.push_back(cont_byte());
        end
        else if (kind < 90)
            ident_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                   : 8'($urandom_range(8'hF8, 8'hFF)));
        else if (kind < 95)
        begin
            // continuation slot holding any byte at all
            ident_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            ident_q.push_back(8'($urandom_range(0, 255)));
        end
        else
            ident_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_ident();
        bit noisy;
        int nchars;
        ident_q.delete();
        noisy  = ($urandom_range(0, 99) < 15);
        nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        repeat (nchars) push_char(noisy);
        // cut the last sequence short
        if (noisy && $urandom_range(0, 2) == 0)
        begin
            case ($urandom_range(0, 2))
                0: ident_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                1:
                begin
                    ident_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                    repeat ($urandom_range(0, 1)) ident_q.push_back(cont_byte());
                end
                default:
                begin
                    ident_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                    repeat ($urandom_range(0, 2)) ident_q.push_back(cont_byte());
                end
            endcase
        end
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        int r;
        int cut;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send_empty(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
            begin
                build_ident();
                if (r < 8)
                begin
                    // abandon the identifier part way with an empty item
                    cut = $urandom_range(1, ident_q.size());
                    for (int i = 0; i < cut; i++)
                        send_byte(ident_q[i], 1'b0);
                    send_empty(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                else
                    send_ident();
            end
        end
    endtask

    // Hold the sender until every queued verdict has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (open_count != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_long_ascii(input int n);
        ident_q.delete();
        repeat (n) ident_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        send_ident();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed cases at the reset limit, no idling
        send_empty(8'h00, 1'b0);
        send_empty(8'hFF, 1'b1);
        ident_q = '{8'h41};                      send_ident();
        ident_q = '{8'h00};                      send_ident();
        ident_q = '{8'h7F};                      send_ident();
        ident_q = '{8'hC3, 8'hA9};               send_ident();
        ident_q = '{8'hEF, 8'hBF, 8'hBF};        send_ident();
        ident_q = '{8'hF0, 8'h90, 8'h80, 8'h80}; send_ident();
        ident_q = '{8'h80};                      send_ident();
        ident_q = '{8'hFF};                      send_ident();
        ident_q = '{8'hC3, 8'h29};               send_ident();
        ident_q = '{8'hE4, 8'hB8};               send_ident();
        send_byte(8'h41, 1'b0);
        send_empty(8'h5A, 1'b0);
        drain();

        write_max_length(8'd1);
        sender_idle_pct = 49;
        run_random(350);
        drain();

        write_max_length(8'd255);
        sender_idle_pct    = 0;
        receiver_stall_pct = 49;
        send_long_ascii(255);
        send_long_ascii(257);
        run_random(350);
        drain();

        write_max_length(8'd12);
        sender_idle_pct    = 35;
        receiver_stall_pct = 35;
        run_random(350);
        drain();

        write_max_length(8'd40);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random(350);
        drain();

        $display("Sent %0d byte items over five phases, limits 64/1/255/12/40, %0d verdicts checked",
                 items_sent, results_checked);
        $display("Verdicts seen: ok %0d, empty %0d, too long %0d, bad character %0d",
                 verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3]);
        if (fail_count == 0 && open_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/u8id_pkg.sv
hw/rtl/u8id_front.sv
hw/rtl/u8id_queue.sv
hw/rtl/u8id_back.sv
hw/rtl/utf8_identifier_checker.sv
dv/u8id_verdict_checker.sv
dv/utf8_identifier_checker_tb.sv
